FILE: sv/tt_pkg.sv
`default_nettype none

package tt_pkg;

  localparam int unsigned DefWidth = 32;
  localparam int unsigned OutWidth = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_GO,
    ST_CHK_WAIT,
    ST_STRIP_GO,
    ST_STRIP_WAIT,
    ST_ACC_GO,
    ST_ACC_WAIT,
    ST_FIN_GO,
    ST_FIN_WAIT,
    ST_DONE
  } state_t;

  // operand pairs for the shared divider
  typedef enum logic [1:0] {
    SEL_COF_BY_D,
    SEL_ACC_BY_D,
    SEL_ACC_BY_COF
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cof_take_q;
    logic     acc_sub_q;
    logic     d_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic d_gt_q;
    logic cof_gt1;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/totient_trial_division.sv
`default_nettype none

// channel  ports                  width   direction
// input    start, busy, in_value  WIDTH   in (busy out)
// result   out_valid, out_totient 32      out
//
// one beat in, one beat out; out_valid is high for a single cycle
// each trial step runs one restoring division on the shared divider; a 32-bit
// prime needs about 65536 divisions
// the shared divider sets the run time, which grows with
// divisors tried + strips + prime factors found
// rst_n is synchronous and returns the controller to idle; busy stays high until
// the result beat, the receiver takes it in the cycle it is shown
module totient_trial_division #(
  parameter int unsigned WIDTH = tt_pkg::DefWidth
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [WIDTH-1:0]            in_value,
  output logic                             out_valid,
  output logic [tt_pkg::OutWidth-1:0]      out_totient
);

  tt_pkg::dp_cmd_t  cmd;
  tt_pkg::dp_sts_t  sts;
  logic [WIDTH-1:0] acc;

  tt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  tt_dpath #(
    .WIDTH(WIDTH)
  ) u_dpath (
    .clk  (clk),
    .rst_n(rst_n),
    .value(in_value),
    .cmd  (cmd),
    .sts  (sts),
    .acc  (acc)
  );

  assign out_totient = tt_pkg::OutWidth'(acc);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(out_valid))
    else $error("busy dropped without a result beat");

endmodule

`default_nettype wire

FILE: sv/tt_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module tt_div #(
  parameter int unsigned WIDTH = tt_pkg::DefWidth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient,
  output logic      [WIDTH-1:0] remainder
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dvs_r;
  logic [CntW-1:0]  cnt_r;
  logic             run_r;
  logic             done_r;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[WIDTH]) begin
      rem_nxt = diff[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CntW'(WIDTH);
      end else if (run_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: sv/tt_dpath.sv
`default_nettype none

module tt_dpath #(
  parameter int unsigned WIDTH = tt_pkg::DefWidth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [WIDTH-1:0] value,
  input  wire tt_pkg::dp_cmd_t  cmd,
  output tt_pkg::dp_sts_t       sts,
  output logic      [WIDTH-1:0] acc
);

  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] cof_r;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic             div_done;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;

  always_comb begin
    case (cmd.div_sel)
      tt_pkg::SEL_COF_BY_D: begin
        op_a = cof_r;
        op_b = d_r;
      end
      tt_pkg::SEL_ACC_BY_D: begin
        op_a = acc_r;
        op_b = d_r;
      end
      tt_pkg::SEL_ACC_BY_COF: begin
        op_a = acc_r;
        op_b = cof_r;
      end
      default: begin
        op_a = cof_r;
        op_b = d_r;
      end
    endcase
  end

  tt_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= value;
      cof_r <= value;
      d_r   <= WIDTH'(2);
    end else begin
      if (cmd.cof_take_q) cof_r <= quo;
      if (cmd.acc_sub_q)  acc_r <= acc_r - quo;
      if (cmd.d_inc)      d_r   <= d_r + WIDTH'(1);
    end
  end

  // d > cof / d is the loop exit test, same as d*d > cof
  always_comb begin
    sts.div_done = div_done;
    sts.rem_zero = (rem == '0);
    sts.d_gt_q   = (d_r > quo);
    sts.cof_gt1  = (cof_r > WIDTH'(1));
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: sv/tt_ctrl.sv
`default_nettype none

module tt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire tt_pkg::dp_sts_t sts,
  output tt_pkg::dp_cmd_t      cmd,
  output logic                 busy,
  output logic                 out_valid
);

  tt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tt_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tt_pkg::ST_IDLE: begin
        if (start) state_nxt = tt_pkg::ST_CHK_GO;
      end
      tt_pkg::ST_CHK_GO:   state_nxt = tt_pkg::ST_CHK_WAIT;
      tt_pkg::ST_CHK_WAIT: begin
        if (sts.div_done) begin
          if (sts.d_gt_q)        state_nxt = tt_pkg::ST_FIN_GO;
          else if (sts.rem_zero) state_nxt = tt_pkg::ST_STRIP_GO;
          else                   state_nxt = tt_pkg::ST_CHK_GO;
        end
      end
      tt_pkg::ST_STRIP_GO:   state_nxt = tt_pkg::ST_STRIP_WAIT;
      tt_pkg::ST_STRIP_WAIT: begin
        if (sts.div_done) begin
          if (sts.rem_zero) state_nxt = tt_pkg::ST_STRIP_GO;
          else              state_nxt = tt_pkg::ST_ACC_GO;
        end
      end
      tt_pkg::ST_ACC_GO:   state_nxt = tt_pkg::ST_ACC_WAIT;
      tt_pkg::ST_ACC_WAIT: begin
        if (sts.div_done) state_nxt = tt_pkg::ST_CHK_GO;
      end
      tt_pkg::ST_FIN_GO: begin
        if (sts.cof_gt1) state_nxt = tt_pkg::ST_FIN_WAIT;
        else             state_nxt = tt_pkg::ST_DONE;
      end
      tt_pkg::ST_FIN_WAIT: begin
        if (sts.div_done) state_nxt = tt_pkg::ST_DONE;
      end
      tt_pkg::ST_DONE: state_nxt = tt_pkg::ST_IDLE;
      default:         state_nxt = tt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_sel = tt_pkg::SEL_COF_BY_D;
    busy       = (state_r != tt_pkg::ST_IDLE);
    out_valid  = 1'b0;
    case (state_r)
      tt_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      tt_pkg::ST_CHK_GO: begin
        cmd.div_start = 1'b1;
      end
      tt_pkg::ST_CHK_WAIT: begin
        if (sts.div_done && !sts.d_gt_q) begin
          cmd.cof_take_q = sts.rem_zero;
          cmd.d_inc      = !sts.rem_zero;
        end
      end
      tt_pkg::ST_STRIP_GO: begin
        cmd.div_start = 1'b1;
      end
      tt_pkg::ST_STRIP_WAIT: begin
        cmd.cof_take_q = sts.div_done && sts.rem_zero;
      end
      tt_pkg::ST_ACC_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tt_pkg::SEL_ACC_BY_D;
      end
      tt_pkg::ST_ACC_WAIT: begin
        cmd.acc_sub_q = sts.div_done;
        cmd.d_inc     = sts.div_done;
      end
      tt_pkg::ST_FIN_GO: begin
        // leftover cofactor above one is a prime factor
        cmd.div_start = sts.cof_gt1;
        cmd.div_sel   = tt_pkg::SEL_ACC_BY_COF;
      end
      tt_pkg::ST_FIN_WAIT: begin
        cmd.acc_sub_q = sts.div_done;
      end
      tt_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
